>>> rtl/evad_pkg.sv
// ----------------------------------------------------------------------------
// evad_pkg
// Shared sizes, register indexes, codes and handshake types of the energy
// voice activity detector.
// ----------------------------------------------------------------------------
package evad_pkg;

	// frame and segment sizing
	localparam int MAX_FRAME_SAMPLES = 1024;
	localparam int PREROLL_DEPTH     = 10;
	localparam int FRAME_MS          = 50;

	// field widths
	localparam int SAMPLE_W  = 16;
	localparam int RMS_W     = 16;
	localparam int FLOOR_W   = 24;
	localparam int MS_W      = 20;
	localparam int TOTAL_W   = 24;
	localparam int PRE_OUT_W = 4;
	localparam int CAUSE_W   = 2;

	// derived sizes
	localparam int LEN_W     = $clog2(MAX_FRAME_SAMPLES + 1);
	localparam int SUM_W     = 2 * SAMPLE_W - 1 + $clog2(MAX_FRAME_SAMPLES);
	localparam int DIVR_W    = (LEN_W > 7) ? LEN_W : 7;
	localparam int DIV_CNT_W = $clog2(SUM_W);
	localparam int RAD_W     = 2 * RMS_W;
	localparam int SQ_CNT_W  = $clog2(RMS_W);
	localparam int PRE_IDX_W = (PREROLL_DEPTH > 1) ? $clog2(PREROLL_DEPTH) : 1;
	localparam int PRE_CNT_W = $clog2(PREROLL_DEPTH + 1);
	localparam int FNUM_W    = 31;

	// digit-serial squaring
	localparam int DIG_W     = 4;
	localparam int MAC_STEPS = SAMPLE_W / DIG_W;
	localparam int STEP_W    = $clog2(MAC_STEPS);
	localparam int MCAND_W   = 2 * SAMPLE_W - DIG_W;
	localparam int PROD_W    = MCAND_W + DIG_W;

	// noise floor arithmetic (Q16.8)
	localparam logic [FLOOR_W-1:0] FLOOR_RESET   = 24'd38400;
	localparam logic [DIVR_W-1:0]  FLOOR_DIVISOR = DIVR_W'(100);

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_ENERGY_THRESHOLD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_FRAMES     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SILENCE_LIMIT_MS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_SEGMENT_S    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SEGMENT_MS   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE_HZ   = 3'd5;

	// segment end causes
	localparam logic [CAUSE_W-1:0] CAUSE_NONE    = 2'd0;
	localparam logic [CAUSE_W-1:0] CAUSE_SILENCE = 2'd1;
	localparam logic [CAUSE_W-1:0] CAUSE_MAXLEN  = 2'd2;

	// divider request and response
	typedef struct packed {
		logic              start;
		logic [SUM_W-1:0]  dividend;
		logic [DIVR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [SUM_W-1:0] quotient;
	} div_rsp_t;

	// result item, first field in the highest bits, last field in the lowest bits
	typedef struct packed {
		logic [TOTAL_W-1:0]   segment_samples;
		logic                 segment_keep;
		logic [CAUSE_W-1:0]   end_cause;
		logic                 segment_end;
		logic [PRE_OUT_W-1:0] preroll_count;
		logic                 speech_start;
		logic [FLOOR_W-1:0]   floor_level;
		logic [RMS_W-1:0]     frame_rms;
		logic                 voiced;
	} res_t;

	localparam int RES_W       = $bits(res_t);
	localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

endpackage

>>> rtl/energy_voice_activity_detector_unit.sv
// ----------------------------------------------------------------------------
// energy_voice_activity_detector_unit
// Frame energy voice activity detector with adaptive noise floor and segment
// start/end tracking; one result per frame-closing sample.
// ----------------------------------------------------------------------------
// Sample flow: a sample is taken in the idle state and is followed by four 4-bit digit
//   steps of the squaring accumulator; samples past the frame limit skip the steps. After
//   a frame-closing sample the input stays closed until its result is handed over.
// Result path: a frame-closing sample passes the bit-serial divider for the mean
//   (41 steps), the 16-step root, while listening a second 41-step divider pass
//   for the floor update and at a speech start the pre-roll sum of the buffered
//   frame lengths, before its result is handed over.
// Reset: arst_n clears all control and detector state, sets the noise floor to
//   150.0 and loads the configuration registers with their defaults.
// ----------------------------------------------------------------------------
module energy_voice_activity_detector_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// sample request
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [evad_pkg::SAMPLE_W-1:0]        s_tdata,  // [15:0] sample
	input  logic                                 s_tlast,  // frame_last
	// frame result
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// [0] voiced, [16:1] frame_rms, [40:17] floor_level, [41] speech_start,
	// [45:42] preroll_count, [46] segment_end, [48:47] end_cause,
	// [49] segment_keep, [73:50] segment_samples, [79:74] zero
	output logic [evad_pkg::OUT_TDATA_W-1:0]     m_tdata,
	// configuration writes
	input  logic                                 cfg_wr_en,
	input  logic [evad_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [evad_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import evad_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_MAC    = 4'd1;
	localparam logic [3:0] S_LDQ    = 4'd2;
	localparam logic [3:0] S_WQ     = 4'd3;
	localparam logic [3:0] S_LDR    = 4'd4;
	localparam logic [3:0] S_WR     = 4'd5;
	localparam logic [3:0] S_EVAL   = 4'd6;
	localparam logic [3:0] S_WF     = 4'd7;
	localparam logic [3:0] S_PSUM   = 4'd8;
	localparam logic [3:0] S_DECIDE = 4'd9;
	localparam logic [3:0] S_OUT    = 4'd10;

	// configuration registers
	logic [14:0] thr_q;
	logic [7:0]  start_frames_q;
	logic [15:0] sil_lim_q;
	logic [9:0]  max_seg_q;
	logic [15:0] min_seg_q;
	logic [15:0] srate_q;

	// control and detector state
	logic [3:0]           state_q;
	logic [STEP_W-1:0]    step_q;
	logic [SUM_W-1:0]     sum_q;
	logic [LEN_W-1:0]     fcnt_q;
	logic [FLOOR_W-1:0]   floor_q;
	logic                 in_speech_q;
	logic [7:0]           vrun_q;
	logic [MS_W-1:0]      silent_q;
	logic [MS_W-1:0]      speech_q;
	logic [PRE_CNT_W-1:0] pfill_q;
	logic [PRE_IDX_W-1:0] pwr_q;
	logic [PRE_CNT_W-1:0] idx_q;
	logic [TOTAL_W-1:0]   total_q;
	logic                 m_tvalid_q;

	// payload
	logic [MCAND_W-1:0]   mcand_q;
	logic [SAMPLE_W-1:0]  mplier_q;
	logic                 last_q;
	logic [LEN_W-1:0]     len_q;
	logic [RMS_W-1:0]     rms_q;
	logic                 voiced_q;
	logic                 start_q;
	logic [PRE_CNT_W-1:0] pre_q;
	logic [31:0]          need_q;
	logic [LEN_W-1:0]     prl_q [PREROLL_DEPTH];
	res_t                 res_q;
	res_t                 out_q;

	// datapath
	logic                 accept;
	logic                 out_free;
	logic                 fcnt_full;
	logic [SAMPLE_W-1:0]  mag;
	logic [PROD_W-1:0]    mac_prod;
	logic [28:0]          rms_scaled;
	logic [28:0]          floor_scaled;
	logic                 voiced_c;
	logic [FNUM_W-1:0]    floor_num;
	logic [7:0]           vrun_next;
	logic [PRE_CNT_W-1:0] fill_next;
	logic [PRE_IDX_W-1:0] pwr_next;
	logic                 start_c;
	logic [MS_W:0]        speech_add;
	logic [MS_W:0]        silent_add;
	logic [TOTAL_W:0]     total_add;
	logic [MS_W-1:0]      max_ms;
	logic [CAUSE_W-1:0]   cause_c;
	logic                 end_c;
	logic [34:0]          keep_lhs;
	logic [34:0]          keep_rhs;
	logic                 keep_c;
	div_req_t             div_req;
	div_rsp_t             div_rsp;
	logic                 sq_start;
	logic                 sq_done;
	logic [RMS_W-1:0]     sq_root;

	assign accept    = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign fcnt_full = (fcnt_q == LEN_W'(MAX_FRAME_SAMPLES));

	// sample magnitude; the most negative sample wraps to 32768 unsigned
	assign mag      = s_tdata[SAMPLE_W-1] ? (SAMPLE_W'(0) - s_tdata) : s_tdata;
	assign mac_prod = PROD_W'(mcand_q) * PROD_W'(mplier_q[DIG_W-1:0]);

	// voiced: rms >= threshold and rms*2560 >= floor*22 (2.2 x floor in Q16.8)
	assign rms_scaled   = 29'(rms_q) * 29'd2560;
	assign floor_scaled = 29'(floor_q) * 29'd22;
	assign voiced_c     = (rms_q >= {1'b0, thr_q}) && (rms_scaled >= floor_scaled);

	// floor numerator: 0.94 floor + 0.06 rms in Q16.8, rounded, before /100
	assign floor_num = FNUM_W'(floor_q) * FNUM_W'(94) + FNUM_W'(rms_q) * FNUM_W'(1536)
		+ FNUM_W'(50);

	// listening bookkeeping
	assign vrun_next = voiced_q ? ((vrun_q == 8'hFF) ? 8'hFF : vrun_q + 8'd1) : 8'd0;
	assign fill_next = (pfill_q == PRE_CNT_W'(PREROLL_DEPTH)) ? pfill_q : pfill_q + 1'b1;
	assign pwr_next  = (pwr_q == PRE_IDX_W'(PREROLL_DEPTH - 1)) ? '0 : pwr_q + 1'b1;
	assign start_c   = (vrun_next >= start_frames_q);

	// segment timers and length, saturating
	assign speech_add = {1'b0, speech_q} + (MS_W + 1)'(FRAME_MS);
	assign silent_add = {1'b0, silent_q} + (MS_W + 1)'(FRAME_MS);
	assign total_add  = {1'b0, total_q} + (TOTAL_W + 1)'(len_q);

	// end test: silence limit wins over maximum length
	assign max_ms  = MS_W'(max_seg_q) * MS_W'(1000);
	assign cause_c = (silent_q >= MS_W'(sil_lim_q)) ? CAUSE_SILENCE :
		(speech_q >= max_ms) ? CAUSE_MAXLEN : CAUSE_NONE;
	assign end_c   = in_speech_q && (cause_c != CAUSE_NONE);

	// keep: 2*total >= floor(2*rate*min/1000)  <=>  2*rate*min < 1000*(2*total+1)
	assign keep_lhs = 35'({need_q, 1'b0});
	assign keep_rhs = 35'({total_q, 1'b1}) * 35'd1000;
	assign keep_c   = (keep_lhs < keep_rhs);

	// shared divider: frame mean first, then the floor update while listening
	always_comb begin
		div_req.start    = (state_q == S_LDQ) || ((state_q == S_EVAL) && !in_speech_q);
		div_req.dividend = (state_q == S_LDQ) ? sum_q : SUM_W'(floor_num);
		div_req.divisor  = (state_q == S_LDQ) ? DIVR_W'(fcnt_q) : FLOOR_DIVISOR;
	end

	evad_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign sq_start = (state_q == S_LDR);

	evad_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (div_rsp.quotient[RAD_W-1:0]),
		.done     (sq_done),
		.root     (sq_root)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q          <= 15'd500;
			start_frames_q <= 8'd3;
			sil_lim_q      <= 16'd800;
			max_seg_q      <= 10'd30;
			min_seg_q      <= 16'd400;
			srate_q        <= 16'd16000;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_ENERGY_THRESHOLD: thr_q          <= cfg_data[14:0];
				REG_START_FRAMES:     start_frames_q <= cfg_data[7:0];
				REG_SILENCE_LIMIT_MS: sil_lim_q      <= cfg_data;
				REG_MAX_SEGMENT_S:    max_seg_q      <= cfg_data[9:0];
				REG_MIN_SEGMENT_MS:   min_seg_q      <= cfg_data;
				REG_SAMPLE_RATE_HZ:   srate_q        <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer and detector state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			sum_q       <= '0;
			fcnt_q      <= '0;
			floor_q     <= FLOOR_RESET;
			in_speech_q <= 1'b0;
			vrun_q      <= '0;
			silent_q    <= '0;
			speech_q    <= '0;
			pfill_q     <= '0;
			pwr_q       <= '0;
			idx_q       <= '0;
			total_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (!fcnt_full) begin
							fcnt_q  <= fcnt_q + 1'b1;
							step_q  <= '0;
							state_q <= S_MAC;
						end else if (s_tlast) begin
							state_q <= S_LDQ;
						end
					end
				end
				S_MAC: begin
					// add one digit's partial product of the square
					sum_q  <= sum_q + SUM_W'(mac_prod);
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(MAC_STEPS - 1)) begin
						state_q <= last_q ? S_LDQ : S_IDLE;
					end
				end
				S_LDQ: begin
					sum_q   <= '0;
					fcnt_q  <= '0;
					state_q <= S_WQ;
				end
				S_WQ: begin
					if (div_rsp.done) begin
						state_q <= S_LDR;
					end
				end
				S_LDR: begin
					state_q <= S_WR;
				end
				S_WR: begin
					if (sq_done) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (in_speech_q) begin
						total_q  <= total_add[TOTAL_W] ? {TOTAL_W{1'b1}} : total_add[TOTAL_W-1:0];
						speech_q <= speech_add[MS_W] ? {MS_W{1'b1}} : speech_add[MS_W-1:0];
						if (voiced_c) begin
							silent_q <= '0;
						end else begin
							silent_q <= silent_add[MS_W] ? {MS_W{1'b1}} : silent_add[MS_W-1:0];
						end
						state_q <= S_DECIDE;
					end else begin
						state_q <= S_WF;
					end
				end
				S_WF: begin
					if (div_rsp.done) begin
						floor_q <= div_rsp.quotient[FLOOR_W-1:0];
						vrun_q  <= vrun_next;
						if (start_c) begin
							in_speech_q <= 1'b1;
							total_q     <= '0;
							idx_q       <= '0;
							pfill_q     <= '0;
							pwr_q       <= '0;
							silent_q    <= '0;
							speech_q    <= '0;
							state_q     <= S_PSUM;
						end else begin
							pfill_q <= fill_next;
							pwr_q   <= pwr_next;
							state_q <= S_DECIDE;
						end
					end
				end
				S_PSUM: begin
					// sum the buffered frame lengths that open the segment
					if (idx_q < pre_q) begin
						total_q <= total_q + TOTAL_W'(prl_q[idx_q[PRE_IDX_W-1:0]]);
						idx_q   <= idx_q + 1'b1;
					end else begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					// segment end drops back to listening state
					if (end_c) begin
						floor_q     <= FLOOR_RESET;
						in_speech_q <= 1'b0;
						vrun_q      <= '0;
						silent_q    <= '0;
						speech_q    <= '0;
						pfill_q     <= '0;
						pwr_q       <= '0;
						total_q     <= '0;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// raise the result request on hand-over, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == S_OUT && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && accept) begin
			mcand_q  <= MCAND_W'(mag);
			mplier_q <= mag;
			last_q   <= s_tlast;
		end
		if (state_q == S_MAC) begin
			mcand_q  <= mcand_q << DIG_W;
			mplier_q <= mplier_q >> DIG_W;
		end
		if (state_q == S_LDQ) begin
			len_q <= fcnt_q;
		end
		if (state_q == S_WR && sq_done) begin
			rms_q <= sq_root;
		end
		if (state_q == S_EVAL) begin
			voiced_q <= voiced_c;
			start_q  <= 1'b0;
			pre_q    <= '0;
			need_q   <= 32'(srate_q) * 32'(min_seg_q);
		end
		if (state_q == S_WF && div_rsp.done) begin
			prl_q[pwr_q] <= len_q;
			if (start_c) begin
				start_q <= 1'b1;
				pre_q   <= fill_next;
			end
		end
		if (state_q == S_DECIDE) begin
			res_q.voiced          <= voiced_q;
			res_q.frame_rms       <= rms_q;
			res_q.floor_level     <= floor_q;
			res_q.speech_start    <= start_q;
			res_q.preroll_count   <= PRE_OUT_W'(pre_q);
			res_q.segment_end     <= end_c;
			res_q.end_cause       <= in_speech_q ? cause_c : CAUSE_NONE;
			res_q.segment_keep    <= end_c && keep_c;
			res_q.segment_samples <= in_speech_q ? total_q : '0;
		end
		if (state_q == S_OUT && out_free) begin
			out_q <= res_q;
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {(OUT_TDATA_W - RES_W)'(0), out_q};

endmodule

>>> rtl/evad_div.sv
// ----------------------------------------------------------------------------
// evad_div
// Bit-serial restoring divider: one quotient bit per cycle, SUM_W quotient bits.
// ----------------------------------------------------------------------------
module evad_div (
	input  logic                clk,
	input  logic                arst_n,
	input  evad_pkg::div_req_t  req,
	output evad_pkg::div_rsp_t  rsp
);
	import evad_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0]     quo_q;
	logic [DIVR_W-1:0]    rem_q;
	logic [DIVR_W-1:0]    dvs_q;
	logic [DIVR_W:0]      trial;
	logic [DIVR_W:0]      diff;
	logic                 fits;

	// shift the next dividend bit into the partial remainder and try a subtract
	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = (trial >= {1'b0, dvs_q});

	// step count and completion
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == DIV_CNT_W'(SUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// dividend shifts out as quotient bits shift in
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[SUM_W-2:0], fits};
			rem_q <= fits ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

>>> rtl/evad_sqrt.sv
// ----------------------------------------------------------------------------
// evad_sqrt
// Digit-by-digit integer square root: two radicand bits and one root bit per
// cycle, RMS_W root bits.
// ----------------------------------------------------------------------------
module evad_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [evad_pkg::RAD_W-1:0]    radicand,
	output logic                          done,
	output logic [evad_pkg::RMS_W-1:0]    root
);
	import evad_pkg::*;

	logic                busy_q;
	logic                done_q;
	logic [SQ_CNT_W-1:0] cnt_q;
	logic [RAD_W-1:0]    rad_q;
	logic [RMS_W+1:0]    rem_q;
	logic [RMS_W-1:0]    root_q;
	logic [RMS_W+3:0]    rem_sh;
	logic [RMS_W+3:0]    trial;
	logic [RMS_W+3:0]    diff;
	logic                fits;

	// bring down the next bit pair and test root*4+1
	assign rem_sh = {rem_q, rad_q[RAD_W-1 -: 2]};
	assign trial  = {2'b00, root_q, 2'b01};
	assign diff   = rem_sh - trial;
	assign fits   = (rem_sh >= trial);

	// step count and completion
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == SQ_CNT_W'(RMS_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// radicand shifts out two bits a step, root grows one bit a step
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q  <= fits ? diff[RMS_W+1:0] : rem_sh[RMS_W+1:0];
			root_q <= {root_q[RMS_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

>>> dv/evad_frame_checker.sv
// ----------------------------------------------------------------------------
// evad_frame_checker
// Watches the sample, result and configuration channels of the voice activity
// detector, predicts the result of every frame-closing sample and compares
// each delivered result with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module evad_frame_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	input  logic                                 s_tready,
	input  logic [evad_pkg::SAMPLE_W-1:0]        s_tdata,   // [15:0] sample
	input  logic                                 s_tlast,   // frame_last
	input  logic                                 m_tvalid,
	input  logic                                 m_tready,
	// [0] voiced, [16:1] frame_rms, [40:17] floor_level, [41] speech_start,
	// [45:42] preroll_count, [46] segment_end, [48:47] end_cause,
	// [49] segment_keep, [73:50] segment_samples, [79:74] zero
	input  logic [evad_pkg::OUT_TDATA_W-1:0]     m_tdata,
	input  logic                                 cfg_wr_en,
	input  logic [evad_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [evad_pkg::CFG_DATA_W-1:0]      cfg_data,
	output int                                   mismatches,
	output int                                   frames_due
);
	timeunit 1ns;
	timeprecision 1ps;
	import evad_pkg::*;

	localparam int unsigned MS_CAP    = (1 << MS_W) - 1;
	localparam int unsigned TOTAL_CAP = (1 << TOTAL_W) - 1;
	localparam int          SHOW_MAX  = 10;

	// register copies
	logic [14:0] thr_rms;
	logic [7:0]  start_run;
	logic [15:0] silence_ms_lim;
	logic [9:0]  max_len_s;
	logic [15:0] min_len_ms;
	logic [15:0] rate_hz;

	// detector state
	longint unsigned   energy_acc;
	int unsigned       frame_len;
	logic [FLOOR_W-1:0] floor_q8;
	bit                talking;
	int unsigned       voiced_streak;
	int unsigned       quiet_ms;
	int unsigned       talk_ms;
	int unsigned       lead_len [PREROLL_DEPTH];
	int unsigned       lead_fill;
	int unsigned       lead_wr;
	int unsigned       seg_len;

	res_t frame_verdicts [$];
	res_t seen;
	res_t due;
	int   fail_count;

	// integer square root, result fits in 16 bits for any frame mean square
	function automatic int unsigned root_of(input longint unsigned v);
		int unsigned     r;
		longint unsigned c;
		r = 0;
		for (int b = 15; b >= 0; b--) begin
			c = 64'(r | (32'd1 << b));
			if (c * c <= v)
				r = int'(c);
		end
		return r;
	endfunction

	function automatic int unsigned sat_sum(input int unsigned a, input int unsigned b,
			input int unsigned lim);
		longint unsigned s;
		s = 64'(a) + 64'(b);
		return (s > 64'(lim)) ? lim : int'(s);
	endfunction

	function automatic string show(input res_t r);
		return $sformatf({"voiced=%0d rms=%0d floor=%0d start=%0d pre=%0d ",
			"end=%0d cause=%0d keep=%0d samples=%0d"},
			r.voiced, r.frame_rms, r.floor_level, r.speech_start, r.preroll_count,
			r.segment_end, r.end_cause, r.segment_keep, r.segment_samples);
	endfunction

	task automatic report_failure(input string msg);
		fail_count++;
		if (fail_count <= SHOW_MAX)
			$display("%0t ns: %s", $realtime, msg);
	endtask

	// return the detector to its listening state; registers are kept
	task automatic restart_detector();
		energy_acc    = 0;
		frame_len     = 0;
		floor_q8      = FLOOR_RESET;
		talking       = 1'b0;
		voiced_streak = 0;
		quiet_ms      = 0;
		talk_ms       = 0;
		for (int i = 0; i < PREROLL_DEPTH; i++)
			lead_len[i] = 0;
		lead_fill = 0;
		lead_wr   = 0;
		seg_len   = 0;
	endtask

	// fold one accepted sample in; a frame-closing sample yields a verdict
	task automatic score_sample(input logic [SAMPLE_W-1:0] raw, input logic closes);
		int              s32;
		int unsigned     len;
		int unsigned     rms;
		bit              loud;
		logic [CAUSE_W-1:0] cause;
		longint unsigned need;
		res_t            verdict;

		s32 = int'($signed(raw));
		if (frame_len < MAX_FRAME_SAMPLES) begin
			energy_acc += 64'(s32 * s32);
			frame_len++;
		end
		if (!closes)
			return;

		len        = frame_len;
		rms        = (len == 0) ? 0 : root_of(energy_acc / 64'(len));
		energy_acc = 0;
		frame_len  = 0;
		loud = (rms >= thr_rms) && (64'(rms) * 64'd2560 >= 64'(floor_q8) * 64'd22);
		verdict = '0;

		if (!talking) begin
			// adapt the floor and remember this frame for the pre-roll
			floor_q8 = FLOOR_W'((64'(floor_q8) * 64'd94 + 64'(rms) * 64'd1536 + 64'd50)
				/ 64'd100);
			lead_len[lead_wr] = len;
			lead_wr = (lead_wr + 1) % PREROLL_DEPTH;
			if (lead_fill < PREROLL_DEPTH)
				lead_fill++;
			voiced_streak = loud ? ((voiced_streak < 255) ? voiced_streak + 1 : 255) : 0;
			if (voiced_streak >= start_run) begin
				verdict.speech_start  = 1'b1;
				verdict.preroll_count = lead_fill[PRE_OUT_W-1:0];
				talking = 1'b1;
				seg_len = 0;
				for (int i = 0; i < lead_fill; i++)
					seg_len = sat_sum(seg_len, lead_len[i], TOTAL_CAP);
				lead_fill = 0;
				lead_wr   = 0;
				quiet_ms  = 0;
				talk_ms   = 0;
			end
		end else begin
			seg_len  = sat_sum(seg_len, len, TOTAL_CAP);
			talk_ms  = sat_sum(talk_ms, FRAME_MS, MS_CAP);
			quiet_ms = loud ? 0 : sat_sum(quiet_ms, FRAME_MS, MS_CAP);
		end

		verdict.voiced      = loud;
		verdict.frame_rms   = rms[RMS_W-1:0];
		verdict.floor_level = floor_q8;

		// close the segment; silence takes precedence over length
		if (talking) begin
			verdict.segment_samples = seg_len[TOTAL_W-1:0];
			cause = CAUSE_NONE;
			if (quiet_ms >= silence_ms_lim)
				cause = CAUSE_SILENCE;
			else if (talk_ms >= max_len_s * 1000)
				cause = CAUSE_MAXLEN;
			if (cause != CAUSE_NONE) begin
				need = 64'(rate_hz) * 64'd2 * 64'(min_len_ms) / 64'd1000;
				verdict.segment_end  = 1'b1;
				verdict.end_cause    = cause;
				verdict.segment_keep = (64'(seg_len) * 64'd2 >= need);
				restart_detector();
			end
		end
		frame_verdicts.insert(frame_verdicts.size(), verdict);
	endtask

	// track writes and requests, compare each delivered result
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_rms        = 15'd500;
			start_run      = 8'd3;
			silence_ms_lim = 16'd800;
			max_len_s      = 10'd30;
			min_len_ms     = 16'd400;
			rate_hz        = 16'd16000;
			restart_detector();
			frame_verdicts.delete();
			fail_count = 0;
			mismatches <= 0;
			frames_due <= 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_ENERGY_THRESHOLD: thr_rms        = cfg_data[14:0];
					REG_START_FRAMES:     start_run      = cfg_data[7:0];
					REG_SILENCE_LIMIT_MS: silence_ms_lim = cfg_data;
					REG_MAX_SEGMENT_S:    max_len_s      = cfg_data[9:0];
					REG_MIN_SEGMENT_MS:   min_len_ms     = cfg_data;
					REG_SAMPLE_RATE_HZ:   rate_hz        = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				score_sample(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				seen = res_t'(m_tdata[RES_W-1:0]);
				if (frame_verdicts.size() == 0) begin
					report_failure({"result with none expected: ", show(seen)});
				end else begin
					due = frame_verdicts[0];
					frame_verdicts.delete(0);
					if (seen.voiced !== due.voiced || seen.frame_rms !== due.frame_rms ||
							seen.floor_level !== due.floor_level ||
							seen.speech_start !== due.speech_start ||
							seen.preroll_count !== due.preroll_count ||
							seen.segment_end !== due.segment_end ||
							seen.end_cause !== due.end_cause ||
							seen.segment_keep !== due.segment_keep ||
							seen.segment_samples !== due.segment_samples)
						report_failure({"frame result differs\n  expected ", show(due),
							"\n  actual   ", show(seen)});
				end
			end
			mismatches <= fail_count;
			frames_due <= frame_verdicts.size();
		end
	end

endmodule

>>> dv/energy_voice_activity_detector_unit_test.sv
// ----------------------------------------------------------------------------
// energy_voice_activity_detector_unit_test
// Drives sample frames and register settings into the voice activity
// detector: a short directed pass over field extremes and segment corner
// cases, then random speech and silence bursts under several settings, with
// random stalls on both channels. A frame checker beside the block predicts
// and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module energy_voice_activity_detector_unit_test;
	timeunit 1ns;
	timeprecision 1ps;
	import evad_pkg::*;

	localparam int ITEM_GOAL     = 1450;
	localparam int SETTLE_CYCLES = 200;
	localparam int CYCLE_LIMIT   = 1_000_000;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [SAMPLE_W-1:0]    s_tdata   = '0;
	logic                   s_tlast   = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;

	int mismatches;
	int frames_due;
	int ticks       = 0;
	int items_sent  = 0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;

	energy_voice_activity_detector_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	evad_frame_checker frame_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.frames_due (frames_due)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// abort a run that hangs
	always @(posedge clk) begin
		ticks <= ticks + 1;
		if (ticks == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// stall the result side in random bursts
	always begin
		@(posedge clk);
		if ($urandom_range(0, 99) < rx_idle_pct) begin
			m_tready <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		m_tready <= 1'b1;
	end

	// offer one sample request, hold it until taken, then maybe pause
	task automatic put_sample(input int value, input logic closes);
		s_tvalid <= 1'b1;
		s_tdata  <= value[SAMPLE_W-1:0];
		s_tlast  <= closes;
		do @(posedge clk); while (!s_tready);
		if ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	endtask

	// random samples within +-amp
	task automatic send_frame(input int len, input int amp);
		for (int i = 0; i < len; i++)
			put_sample(int'($urandom_range(0, 2 * amp)) - amp, i == len - 1);
		items_sent += len;
	endtask

	// drain all results and let the block go quiet
	task automatic settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (frames_due != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	task automatic program_detector(input logic [15:0] thr, input logic [15:0] starts,
			input logic [15:0] sil_ms, input logic [15:0] max_s, input logic [15:0] min_ms,
			input logic [15:0] rate);
		write_reg(REG_ENERGY_THRESHOLD, thr);
		write_reg(REG_START_FRAMES, starts);
		write_reg(REG_SILENCE_LIMIT_MS, sil_ms);
		write_reg(REG_MAX_SEGMENT_S, max_s);
		write_reg(REG_MIN_SEGMENT_MS, min_ms);
		write_reg(REG_SAMPLE_RATE_HZ, rate);
		cfg_wr_en <= 1'b0;
	endtask

	// mostly workable settings, now and then every register at an extreme
	task automatic random_setting();
		logic [15:0] thr, starts, sil_ms, max_s, min_ms, rate;
		if ($urandom_range(0, 5) == 0) begin
			thr    = $urandom_range(0, 1) ? 16'd32767 : 16'd0;
			case ($urandom_range(0, 2))
				0:       starts = 16'd0;
				1:       starts = 16'd1;
				default: starts = 16'd255;
			endcase
			sil_ms = $urandom_range(0, 1) ? 16'hFFFF : 16'd0;
			max_s  = $urandom_range(0, 1) ? 16'd1023 : 16'd0;
			min_ms = $urandom_range(0, 1) ? 16'hFFFF : 16'd0;
			rate   = $urandom_range(0, 1) ? 16'hFFFF : 16'd0;
		end else begin
			thr    = 16'($urandom_range(0, 1500));
			starts = 16'($urandom_range(1, 5));
			sil_ms = 16'(50 * $urandom_range(0, 8));
			max_s  = 16'($urandom_range(0, 2));
			min_ms = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
				: 16'($urandom_range(0, 6));
			rate   = 16'($urandom_range(8000, 48000));
		end
		program_detector(thr, starts, sil_ms, max_s, min_ms, rate);
	endtask

	initial begin
		int frame_total;
		int run_left;
		bit loud;
		bit long_sent;

		run_left  = 0;
		loud      = 1'b0;
		long_sent = 1'b0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 20;
		rx_idle_pct = 20;

		// default settings: three loud frames at the sample extremes open a segment
		put_sample(32767, 1'b1);
		put_sample(-32768, 1'b1);
		put_sample(20000, 1'b0);
		put_sample(-20000, 1'b1);
		put_sample(0, 1'b0);
		put_sample(1, 1'b0);
		put_sample(-1, 1'b1);
		put_sample(21845, 1'b0);
		put_sample(-21846, 1'b1);

		// silence limit zero ends the open segment on the next frame
		settle();
		program_detector(16'd500, 16'd3, 16'd0, 16'd30, 16'd400, 16'd16000);
		put_sample(0, 1'b1);

		// start threshold zero with both end causes at once
		settle();
		program_detector(16'd500, 16'd0, 16'd0, 16'd0, 16'd0, 16'd16000);
		put_sample(12345, 1'b1);

		// maximum length zero ends the segment it just opened
		settle();
		program_detector(16'd0, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF);
		put_sample(-7, 1'b1);

		// top threshold, only full-scale frames count as voiced
		settle();
		program_detector(16'd32767, 16'd1, 16'hFFFF, 16'd1023, 16'hFFFF, 16'hFFFF);
		put_sample(32767, 1'b1);
		put_sample(-32768, 1'b0);
		put_sample(32767, 1'b1);

		// zero rate and threshold, silence closes the segment
		settle();
		program_detector(16'd0, 16'd255, 16'd0, 16'd1, 16'd0, 16'd0);
		put_sample(0, 1'b1);

		// random speech and silence bursts under changing settings
		while (items_sent < ITEM_GOAL) begin
			settle();
			random_setting();
			if (items_sent > ITEM_GOAL - 200) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end else begin
				tx_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
				rx_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
			end
			// one frame past the length limit
			if (!long_sent && items_sent > ITEM_GOAL / 8) begin
				send_frame(MAX_FRAME_SAMPLES + $urandom_range(1, 24), $urandom_range(6000, 32768));
				long_sent = 1'b1;
			end
			frame_total = $urandom_range(15, 45);
			for (int f = 0; f < frame_total; f++) begin
				if (run_left == 0) begin
					loud     = !loud;
					run_left = loud ? $urandom_range(1, 10) : $urandom_range(1, 12);
				end
				run_left--;
				if ($urandom_range(0, 9) == 0)
					send_frame($urandom_range(1, 30), $urandom_range(0, 32768));
				else
					send_frame(($urandom_range(0, 4) == 0) ? $urandom_range(5, 16)
						: $urandom_range(1, 3),
						loud ? $urandom_range(6000, 32768) : $urandom_range(0, 250));
			end
		end

		settle();
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

>>> filelist.f
rtl/evad_pkg.sv
rtl/evad_div.sv
rtl/evad_sqrt.sv
rtl/energy_voice_activity_detector_unit.sv
dv/evad_frame_checker.sv
dv/energy_voice_activity_detector_unit_test.sv
